// ----- design/bba_pkg.sv -----
// Shared constants, codes and map helpers for the buddy block allocator.
// No dependencies; bba_if, bba_scan and the allocator refer to it by scoped name.
`default_nettype none
package bba_pkg;

  localparam int MIN_SHIFT   = 12;   // log2 of the minimum block size in bytes
  localparam int MB_W        = 10;   // minimum block index width
  localparam int LVL_W       = 4;
  localparam int TOP_LEVEL   = 10;
  localparam int NUM_LEVELS  = TOP_LEVEL + 1;
  localparam int WORD_W      = 32;
  localparam int WORD_SH     = 5;
  localparam int MAP_WORDS   = 68;   // free bitmap words over all levels
  localparam int MAP_AW      = 7;
  localparam int LROWS       = 32;   // level store rows, 32 fields each
  localparam int LROW_AW     = 5;
  localparam int ROW_W       = 128;
  localparam int SIZE_W      = 23;
  localparam int OFF_W       = 22;

  localparam logic [1:0] OP_ALLOC       = 2'd0;
  localparam logic [1:0] OP_ALLOC_ALIGN = 2'd1;
  localparam logic [1:0] OP_FREE        = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_NO_MEM    = 3'd2;
  localparam logic [2:0] ST_NO_LEVEL  = 3'd3;
  localparam logic [2:0] ST_BAD_ALIGN = 3'd4;

  // Words of free bitmap at one level (at least one).
  function automatic logic [5:0] map_words(input logic [LVL_W-1:0] lv);
    logic [5:0] w;
    w = (lv < 4'd5) ? (6'd32 >> lv) : 6'd1;
    return w;
  endfunction

  // First bitmap word of one level.
  function automatic logic [MAP_AW-1:0] map_base(input logic [LVL_W-1:0] lv);
    logic [MAP_AW-1:0] b;
    b = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (LVL_W'(l) < lv) b = b + MAP_AW'(map_words(LVL_W'(l)));
    end
    return b;
  endfunction

  function automatic logic [MAP_AW-1:0] map_addr(input logic [LVL_W-1:0] lv,
                                                 input logic [MB_W-1:0] i);
    logic [MAP_AW-1:0] a;
    a = map_base(lv) + {2'b00, i[MB_W-1:WORD_SH]};
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- design/bba_if.sv -----
// Request and response channel interfaces of the buddy block allocator.
// Depends on bba_pkg for field widths.
`default_nettype none
interface bba_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [bba_pkg::SIZE_W-1:0]  size_bytes;
  logic [bba_pkg::SIZE_W-1:0]  align_bytes;
  logic [bba_pkg::OFF_W-1:0]   free_offset;
  modport source(output valid, op, size_bytes, align_bytes, free_offset, input ready);
  modport sink(input valid, op, size_bytes, align_bytes, free_offset, output ready);
endinterface

interface bba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::OFF_W-1:0]   offset;
  logic [2:0]                  status;
  logic [bba_pkg::SIZE_W-1:0]  used_bytes;
  modport source(output valid, offset, status, used_bytes, input ready);
  modport sink(input valid, offset, status, used_bytes, output ready);
endinterface
`default_nettype wire

// ----- design/bba_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/bba_scan.sv -----
// Lowest set bit finder over one free bitmap word.
// Depends on bba_pkg for the word width.
`default_nettype none
module bba_scan (
  input  wire logic [bba_pkg::WORD_W-1:0]  word,
  output logic                             any,
  output logic      [bba_pkg::WORD_SH-1:0] pos
);
  always_comb begin
    any = |word;
    pos = '0;
    for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (word[i]) pos = bba_pkg::WORD_SH'(i);
    end
  end
endmodule
`default_nettype wire

// ----- design/buddy_block_allocator.sv -----
// Buddy block allocator: 1024 blocks of 4 KiB, levels 0..10, one request at a time.
// Allocation scans up to 68 bitmap words, splits the found block down level by level
// and writes up to 32 level store rows; a free reads the block's level, checks the
// levels above it and merges free buddies upward; rejected or unused requests respond
// directly. Reset (rst, synchronous) runs a clearing pass over every word of the free
// bitmap RAM, leaving only the whole pool free.
`default_nettype none
module buddy_block_allocator (
  input wire logic clk,
  input wire logic rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp
);
  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SRCH_RD  = 4'd2;
  localparam logic [3:0] S_SRCH_CHK = 4'd3;
  localparam logic [3:0] S_SPLT_RD  = 4'd4;
  localparam logic [3:0] S_SPLT_WR  = 4'd5;
  localparam logic [3:0] S_LVL_RD   = 4'd6;
  localparam logic [3:0] S_LVL_WR   = 4'd7;
  localparam logic [3:0] S_FLV_RD   = 4'd8;
  localparam logic [3:0] S_FLV_CHK  = 4'd9;
  localparam logic [3:0] S_FCHK_RD  = 4'd10;
  localparam logic [3:0] S_FCHK_CHK = 4'd11;
  localparam logic [3:0] S_MRG_RD   = 4'd12;
  localparam logic [3:0] S_MRG_CHK  = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  localparam logic [bba_pkg::LVL_W-1:0] TOP = bba_pkg::LVL_W'(bba_pkg::TOP_LEVEL);

  logic [3:0]                         state;
  logic [bba_pkg::LVL_W-1:0]          lv, cl;
  logic [bba_pkg::MB_W-1:0]           idx, ml;
  logic [bba_pkg::WORD_SH-1:0]        wcnt;
  logic [5:0]                         rowc;
  logic [bba_pkg::MAP_AW-1:0]         clr_cnt;
  logic [bba_pkg::SIZE_W-1:0]         used;
  logic [bba_pkg::OFF_W-1:0]          offs;
  logic [2:0]                         status;
  logic                               out_valid;
  logic [bba_pkg::OFF_W-1:0]          out_offset;
  logic [2:0]                         out_status;
  logic [bba_pkg::SIZE_W-1:0]         out_used;

  // map RAM ports
  logic                               m_we;
  logic [bba_pkg::MAP_AW-1:0]         m_waddr, m_raddr;
  logic [bba_pkg::WORD_W-1:0]         m_wdata, m_rdata;
  // level store RAM ports
  logic                               l_we;
  logic [bba_pkg::LROW_AW-1:0]        l_row;
  logic [bba_pkg::ROW_W-1:0]          l_wdata, l_rdata;

  logic                               sc_any;
  logic [bba_pkg::WORD_SH-1:0]        sc_pos;

  bba_ram #(.WIDTH(bba_pkg::WORD_W), .DEPTH(bba_pkg::MAP_WORDS)) u_map (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  bba_ram #(.WIDTH(bba_pkg::ROW_W), .DEPTH(bba_pkg::LROWS)) u_lvl (
    .clk(clk), .we(l_we), .waddr(l_row), .wdata(l_wdata),
    .raddr(l_row), .rdata(l_rdata)
  );

  bba_scan u_scan (.word(m_rdata), .any(sc_any), .pos(sc_pos));

  // request decode
  logic                       fit;
  logic [bba_pkg::LVL_W-1:0]  fit_lv;
  logic                       align_bad;
  logic [bba_pkg::SIZE_W-1:0] lbytes;

  always_comb begin
    fit    = 1'b0;
    fit_lv = '0;
    for (int l = bba_pkg::TOP_LEVEL; l >= 0; l--) begin
      lbytes = bba_pkg::SIZE_W'(23'd4096 << l);
      if (lbytes >= req.size_bytes &&
          (req.op == bba_pkg::OP_ALLOC || lbytes >= req.align_bytes)) begin
        fit    = 1'b1;
        fit_lv = bba_pkg::LVL_W'(l);
      end
    end
    align_bad = (req.align_bytes == '0) ||
                ((req.align_bytes & (req.align_bytes - 23'd1)) != '0);
  end

  // derived values of the current step
  logic [bba_pkg::MB_W-1:0]     start;
  logic [bba_pkg::MB_W-1:0]     mshift;
  logic [bba_pkg::LVL_W-1:0]    fld_lv;
  logic [bba_pkg::SIZE_W-1:0]   blk_bytes;
  logic [5:0]                   nrows;
  logic [bba_pkg::WORD_W-1:0]   bitmask, buddymask;

  always_comb begin
    start     = idx << lv;
    mshift    = ml >> cl;
    fld_lv    = l_rdata[{ml[4:0], 2'b00} +: bba_pkg::LVL_W];
    blk_bytes = bba_pkg::SIZE_W'(23'd4096 << lv);
    nrows     = (lv >= 4'd5) ? (6'd1 << (lv - 4'd5)) : 6'd1;
    bitmask   = bba_pkg::WORD_W'(1) << idx[4:0];
    buddymask = bba_pkg::WORD_W'(1) << (idx[4:0] ^ 5'd1);
  end

  // memory control
  always_comb begin
    m_we    = 1'b0;
    m_waddr = bba_pkg::map_addr(cl, idx);
    m_wdata = m_rdata;
    m_raddr = bba_pkg::map_addr(cl, idx);
    l_we    = 1'b0;
    l_row   = start[9:5] + rowc[4:0];
    l_wdata = l_rdata;
    unique case (state)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_cnt;
        m_wdata = (clr_cnt == bba_pkg::map_base(TOP)) ? 32'd1 : 32'd0;
      end
      S_SRCH_RD, S_SRCH_CHK: begin
        m_raddr = bba_pkg::map_base(cl) + {2'b00, wcnt};
        m_waddr = bba_pkg::map_base(cl) + {2'b00, wcnt};
        m_we    = (state == S_SRCH_CHK) && sc_any;
        m_wdata = m_rdata & ~(bba_pkg::WORD_W'(1) << sc_pos);
      end
      S_SPLT_WR: begin
        m_we    = 1'b1;
        m_wdata = m_rdata | buddymask;
      end
      S_LVL_WR: begin
        l_we = 1'b1;
        for (int f = 0; f < 32; f++) begin
          if (lv >= 4'd5 || ((5'(f) >> lv) == (start[4:0] >> lv)))
            l_wdata[f*4 +: 4] = lv;
        end
      end
      S_FLV_RD, S_FLV_CHK: l_row = ml[9:5];
      S_FCHK_RD, S_FCHK_CHK: m_raddr = bba_pkg::map_addr(cl, mshift);
      S_MRG_CHK: begin
        m_we    = 1'b1;
        m_wdata = (cl < TOP && (m_rdata & buddymask) != '0) ? (m_rdata & ~buddymask)
                                                            : (m_rdata | bitmask);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 7'd1;
          if (clr_cnt == 7'(bba_pkg::MAP_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          offs   <= '0;
          status <= bba_pkg::ST_OK;
          ml     <= req.free_offset[21:12];
          rowc   <= '0;
          wcnt   <= '0;
          if (req.op == bba_pkg::OP_ALLOC || req.op == bba_pkg::OP_ALLOC_ALIGN) begin
            lv <= fit_lv;
            cl <= fit_lv;
            if (req.size_bytes > 23'd4194304) begin
              status <= bba_pkg::ST_TOO_LARGE;
              state  <= S_DONE;
            end else if (req.op == bba_pkg::OP_ALLOC_ALIGN && align_bad) begin
              status <= bba_pkg::ST_BAD_ALIGN;
              state  <= S_DONE;
            end else if (!fit) begin
              status <= bba_pkg::ST_NO_LEVEL;
              state  <= S_DONE;
            end else begin
              state <= S_SRCH_RD;
            end
          end else if (req.op == bba_pkg::OP_FREE) begin
            state <= S_FLV_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SRCH_RD: state <= S_SRCH_CHK;
        S_SRCH_CHK: begin
          if (sc_any) begin
            if (cl > lv) begin
              cl    <= cl - 4'd1;
              idx   <= {wcnt[3:0], sc_pos, 1'b0};
              state <= S_SPLT_RD;
            end else begin
              idx   <= {wcnt, sc_pos};
              state <= S_LVL_RD;
            end
          end else if ({1'b0, wcnt} + 6'd1 < bba_pkg::map_words(cl)) begin
            wcnt  <= wcnt + 5'd1;
            state <= S_SRCH_RD;
          end else if (cl < TOP) begin
            cl    <= cl + 4'd1;
            wcnt  <= '0;
            state <= S_SRCH_RD;
          end else begin
            status <= bba_pkg::ST_NO_MEM;
            state  <= S_DONE;
          end
        end
        S_SPLT_RD: state <= S_SPLT_WR;
        S_SPLT_WR: begin
          // upper half now free, descend with the lower half
          if (cl > lv) begin
            cl    <= cl - 4'd1;
            idx   <= {idx[8:0], 1'b0};
            state <= S_SPLT_RD;
          end else begin
            state <= S_LVL_RD;
          end
        end
        S_LVL_RD: state <= S_LVL_WR;
        S_LVL_WR: begin
          if (rowc + 6'd1 == nrows) begin
            used  <= used + blk_bytes;
            offs  <= {start, 12'b0};
            state <= S_DONE;
          end else begin
            rowc  <= rowc + 6'd1;
            state <= S_LVL_RD;
          end
        end
        S_FLV_RD: state <= S_FLV_CHK;
        S_FLV_CHK: begin
          lv <= fld_lv;
          cl <= fld_lv;
          if (fld_lv > TOP || (ml & ((10'd1 << fld_lv) - 10'd1)) != '0)
            state <= S_DONE;
          else
            state <= S_FCHK_RD;
        end
        S_FCHK_RD: state <= S_FCHK_CHK;
        S_FCHK_CHK: begin
          if (m_rdata[mshift[4:0]]) begin
            state <= S_DONE;   // already free: drop
          end else if (cl < TOP) begin
            cl    <= cl + 4'd1;
            state <= S_FCHK_RD;
          end else begin
            used  <= (used >= blk_bytes) ? used - blk_bytes : '0;
            cl    <= lv;
            idx   <= ml >> lv;
            state <= S_MRG_RD;
          end
        end
        S_MRG_RD: state <= S_MRG_CHK;
        S_MRG_CHK: begin
          if (cl < TOP && (m_rdata & buddymask) != '0) begin
            cl    <= cl + 4'd1;
            idx   <= idx >> 1;
            state <= S_MRG_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: if (!out_valid || rsp.ready) begin
          out_valid  <= 1'b1;
          out_offset <= offs;
          out_status <= status;
          out_used   <= used;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.offset     = out_offset;
  assign rsp.status     = out_status;
  assign rsp.used_bytes = out_used;
endmodule
`default_nettype wire

// ----- bench/tb_buddy_block_allocator.sv -----
// Self-checking testbench for buddy_block_allocator: directed and random requests,
// each response checked against an in-bench buddy pool model.
// Depends on bba_pkg, bba_if.sv and the allocator RTL.
`timescale 1ns / 100ps
module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int POOL_BLOCKS = 1024;
  localparam int POOL_BYTES  = 4194304;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 400;
  localparam int MIN_BLOCK_SZ = 1 << MIN_SHIFT;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [2:0]        status;
    logic [SIZE_W-1:0] used;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bba_req_if req_ch();
  bba_rsp_if rsp_ch();

  buddy_block_allocator u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #1 clk = ~clk;

  // pool model
  bit            free_bit [0:TOP_LEVEL][0:POOL_BLOCKS-1];
  bit [3:0]      block_lvl [0:POOL_BLOCKS-1];
  bit            lvl_known [0:POOL_BLOCKS-1];
  int            known_blocks[$];
  int            live_offsets[$];
  int            bytes_in_use;
  alloc_result_t expected_results[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic logic [OFF_W-1:0] foff_rand();
    return OFF_W'($urandom());
  endfunction

  task automatic pool_reset();
    for (int l = 0; l <= TOP_LEVEL; l++)
      for (int i = 0; i < POOL_BLOCKS; i++) free_bit[l][i] = 1'b0;
    free_bit[TOP_LEVEL][0] = 1'b1;
    bytes_in_use = 0;
  endtask

  // Take the lowest free block at or above lv and split it down.
  task automatic take_block(input int lv, output bit ok, output int start);
    int cl, idx, k;
    ok = 1'b0;
    idx = 0;
    for (cl = lv; cl <= TOP_LEVEL && !ok; cl++) begin
      for (idx = 0; idx < (POOL_BLOCKS >> cl); idx++)
        if (free_bit[cl][idx]) begin
          ok = 1'b1;
          break;
        end
      if (ok) break;
    end
    start = 0;
    if (!ok) return;
    free_bit[cl][idx] = 1'b0;
    while (cl > lv) begin
      cl--;
      idx = idx << 1;
      free_bit[cl][idx + 1] = 1'b1;
    end
    start = idx << lv;
    for (k = 0; k < (1 << lv); k++) begin
      block_lvl[start + k] = 4'(lv);
      if (!lvl_known[start + k]) known_blocks = {known_blocks, start + k};
      lvl_known[start + k] = 1'b1;
    end
    bytes_in_use = (bytes_in_use + (MIN_BLOCK_SZ << lv)) & 32'h7FFFFF;
  endtask

  task automatic release_block(input int byte_off);
    int m, lv, idx, sz;
    m = byte_off >> MIN_SHIFT;
    if (m >= POOL_BLOCKS) return;
    lv = block_lvl[m];
    if (lv > TOP_LEVEL) return;
    if ((m & ((1 << lv) - 1)) != 0) return;
    for (int k = lv; k <= TOP_LEVEL; k++)
      if (free_bit[k][m >> k]) return;
    sz = MIN_BLOCK_SZ << lv;
    bytes_in_use = (bytes_in_use >= sz) ? bytes_in_use - sz : 0;
    foreach (live_offsets[i])
      if (live_offsets[i] == (m << MIN_SHIFT)) begin
        live_offsets.delete(i);
        break;
      end
    idx = m >> lv;
    while (lv < TOP_LEVEL && free_bit[lv][idx ^ 1]) begin
      free_bit[lv][idx ^ 1] = 1'b0;
      idx = idx >> 1;
      lv++;
    end
    free_bit[lv][idx] = 1'b1;
  endtask

  task automatic predict_response(input logic [1:0] op, input longint size,
                                  input longint align, input int foff);
    alloc_result_t r;
    longint off;
    int lv, start;
    bit fits, ok;
    off = 0;
    r.status = ST_OK;
    if (op == OP_ALLOC || op == OP_ALLOC_ALIGN) begin
      if (size > POOL_BYTES) begin
        r.status = ST_TOO_LARGE;
      end else if (op == OP_ALLOC_ALIGN && (align == 0 || (align & (align - 1)) != 0)) begin
        r.status = ST_BAD_ALIGN;
      end else begin
        fits = 1'b0;
        for (lv = 0; lv <= TOP_LEVEL; lv++)
          if ((longint'(MIN_BLOCK_SZ) << lv) >= size &&
              (op == OP_ALLOC || (longint'(MIN_BLOCK_SZ) << lv) >= align)) begin
            fits = 1'b1;
            break;
          end
        if (!fits) begin
          r.status = ST_NO_LEVEL;
        end else begin
          take_block(lv, ok, start);
          if (!ok) begin
            r.status = ST_NO_MEM;
          end else begin
            off = longint'(start) * MIN_BLOCK_SZ;
            if (op == OP_ALLOC_ALIGN && (off % align) != 0) off += align - (off % align);
            live_offsets = {live_offsets, start << MIN_SHIFT};
          end
        end
      end
    end else if (op == OP_FREE) begin
      release_block(foff);
    end
    r.offset = OFF_W'(off);
    r.used   = SIZE_W'(bytes_in_use);
    expected_results = {expected_results, r};
  endtask

  // Send one request; valid stays high after acceptance until the next call decides.
  task automatic send_request(input logic [1:0] op, input logic [SIZE_W-1:0] size,
                              input logic [SIZE_W-1:0] align, input logic [OFF_W-1:0] foff);
    while (chance(idle_pct)) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.size_bytes  <= size;
    req_ch.align_bytes <= align;
    req_ch.free_offset <= foff;
    do @(posedge clk); while (!req_ch.ready);
    predict_response(op, size, align, foff);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // response checker and ready stalls
  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: offset=%0h status=%0d used=%0h",
                   rsp_ch.offset, rsp_ch.status, rsp_ch.used_bytes);
      end else begin
        e = expected_results.pop_front();
        if (rsp_ch.offset !== e.offset || rsp_ch.status !== e.status ||
            rsp_ch.used_bytes !== e.used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: offset exp %0h got %0h, status exp %0d got %0d, used exp %0h got %0h",
                     e.offset, rsp_ch.offset, e.status, rsp_ch.status, e.used, rsp_ch.used_bytes);
        end
      end
    end
    rsp_ch.ready <= !chance(stall_pct);
  end

  // watchdog: no progress while work is pending
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (!req_ch.valid && expected_results.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_alloc_extremes();
    send_request(OP_ALLOC, 23'd4194304, '0, '0);       // whole pool
    send_request(OP_ALLOC, 23'd0, '0, '0);             // out of memory
    send_request(OP_ALLOC, 23'd4194305, '0, '0);       // too large
    send_request(OP_ALLOC, 23'h7FFFFF, 23'h7FFFFF, '0);
    send_request(OP_ALLOC_ALIGN, 23'h7FFFFF, 23'd0, '0);
    send_request(OP_FREE, '0, '0, 22'h000ABC);
    send_request(OP_ALLOC, 23'd0, '0, '0);             // size zero at smallest level
    send_request(OP_ALLOC, 23'd1, '0, '0);
    send_request(OP_ALLOC, 23'd4096, '0, '0);
    send_request(OP_ALLOC, 23'd4097, '0, '0);
    send_request(OP_ALLOC_ALIGN, 23'd16, 23'd0, '0);   // zero alignment
    send_request(OP_ALLOC_ALIGN, 23'd16, 23'd3, '0);   // not a power of two
    send_request(OP_ALLOC_ALIGN, 23'd0, 23'd1, '0);
    send_request(OP_ALLOC_ALIGN, 23'd0, 23'd65536, '0);
    send_request(OP_ALLOC_ALIGN, 23'd0, 23'h400000, '0); // OOM at top level
    send_request(OP_UNUSED, 23'h7FFFFF, 23'h7FFFFF, 22'h3FFFFF);
  endtask

  task automatic test_free_cases();
    send_request(OP_FREE, '0, '0, 22'(32'h3000));      // single-block allocation at block 3
    send_request(OP_FREE, '0, '0, 22'(32'h2FFF));      // offset within block start page
    send_request(OP_FREE, '0, '0, 22'(32'h2000));      // double free
    while (live_offsets.size() != 0) send_request(OP_FREE, '0, '0, 22'(live_offsets[0]));
    send_request(OP_FREE, '0, '0, 22'h0);              // already merged into the free pool
  endtask

  task automatic test_random_traffic(input int n, input int idle, input int stall);
    int sel, m;
    logic [SIZE_W-1:0] size, align;
    logic [OFF_W-1:0] foff;
    wait_drained();
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99, 0);
      // free more when the pool is crowded
      if (live_offsets.size() > 0 && bytes_in_use > POOL_BYTES / 2) sel = 70;
      if (sel < 55 || (live_offsets.size() == 0 && sel < 95)) begin
        case ($urandom_range(9, 0))
          0:       size = SIZE_W'($urandom());
          1:       size = SIZE_W'($urandom_range(POOL_BYTES, 0));
          default: size = SIZE_W'($urandom_range(65536, 0));
        endcase
        if (chance(40)) begin
          align = chance(85) ? SIZE_W'(1) << $urandom_range(16, 0)
                             : (chance(50) ? SIZE_W'(1) << $urandom_range(22, 0)
                                           : SIZE_W'($urandom()));
          send_request(OP_ALLOC_ALIGN, size, align, foff_rand());
        end else begin
          send_request(OP_ALLOC, size, SIZE_W'($urandom()), foff_rand());
        end
      end else if (sel < 95) begin
        if (chance(75) && live_offsets.size() != 0) begin
          foff = 22'(live_offsets[$urandom_range(live_offsets.size() - 1, 0)]);
          if (chance(30)) foff[MIN_SHIFT-1:0] = 12'($urandom());
        end else begin
          // interior or stale blocks whose level is known
          m = known_blocks[$urandom_range(known_blocks.size() - 1, 0)];
          foff = {10'(m), 12'($urandom())};
        end
        send_request(OP_FREE, SIZE_W'($urandom()), SIZE_W'($urandom()), foff);
      end else begin
        send_request(OP_UNUSED, SIZE_W'($urandom()), SIZE_W'($urandom()), foff_rand());
      end
    end
  endtask

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_ALLOC;
    req_ch.size_bytes  = '0;
    req_ch.align_bytes = '0;
    req_ch.free_offset = '0;
    rsp_ch.ready       = 1'b0;
    pool_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_alloc_extremes();
    test_free_cases();
    test_random_traffic(200, 0, 0);
    test_random_traffic(200, 73, 0);
    test_random_traffic(200, 0, 73);
    test_random_traffic(200, 6, 6);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bba_pkg.sv
design/bba_if.sv
design/bba_ram.sv
design/bba_scan.sv
design/buddy_block_allocator.sv
bench/tb_buddy_block_allocator.sv
